// ===== hw/rtl/stereo_frame_timestamp_pairing_defines.svh =====
// Assertion macros used by the checker of the stereo frame pairing block.
`ifndef STEREO_FRAME_TIMESTAMP_PAIRING_DEFINES_SVH
`define STEREO_FRAME_TIMESTAMP_PAIRING_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SFTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SFTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sftp_pkg.sv =====
// Types and constants of the stereo frame timestamp pairing block.
`timescale 1ns / 1ps

package sftp_pkg;

  localparam int unsigned TimeBits = 64;
  localparam int unsigned TagBits  = 8;
  localparam int unsigned GapBits  = 32;

  localparam logic [GapBits-1:0] GapReset = 32'd30000000;

  // Command codes of an input request.
  localparam logic [1:0] CmdPushLeft  = 2'd0;
  localparam logic [1:0] CmdPushRight = 2'd1;
  localparam logic [1:0] CmdPop       = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    StStored     = 3'd0,
    StStoredDrop = 3'd1,
    StPair       = 3'd2,
    StNoPair     = 3'd3,
    StEmpty      = 3'd4
  } status_e;

  // One queued frame.
  typedef struct packed {
    logic [TimeBits-1:0] stamp;
    logic [TagBits-1:0]  tag;
  } entry_t;

  // Input request payload.
  typedef struct packed {
    logic [1:0]          command;
    logic [TimeBits-1:0] frame_time;
    logic [7:0]          frame_tag;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [2:0]          status;
    logic [TimeBits-1:0] left_time;
    logic [7:0]          left_tag;
    logic [TimeBits-1:0] right_time;
    logic [7:0]          right_tag;
  } out_t;

endpackage

// ===== hw/rtl/sftp_queue.sv =====
// Bounded circular frame queue with one write port and one registered read port.
`timescale 1ns / 1ps

module sftp_queue #(
  parameter int unsigned Depth = 30,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sftp_pkg::entry_t    push_data_i,
  input  logic                adv_i,
  input  logic [CntW-1:0]     adv_n_i,
  input  logic [CntW-1:0]     rd_off_i,
  output sftp_pkg::entry_t    rd_data_o,
  output logic [CntW-1:0]     count_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CntW:0] DepthW = (CntW + 1)'(Depth);

  sftp_pkg::entry_t mem_q [Depth];
  sftp_pkg::entry_t rd_data_q;
  logic [IdxW-1:0]  head_q;
  logic [CntW-1:0]  count_q;
  logic             full;
  logic [IdxW-1:0]  wr_addr;
  logic [IdxW-1:0]  rd_addr;

  // Physical slot of the entry k places behind the head; the sum stays below twice the depth.
  function automatic logic [IdxW-1:0] slot(logic [IdxW-1:0] h, logic [CntW-1:0] k);
    logic [CntW:0] s;
    s = (CntW + 1)'(h) + {1'b0, k};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[IdxW-1:0];
  endfunction

  assign full    = (count_q == CntW'(Depth));
  assign wr_addr = full ? head_q : slot(head_q, count_q);
  assign rd_addr = slot(head_q, rd_off_i);

  // Head and fill count; a push into a full queue overwrites the oldest entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (push_i) begin
      if (full) begin
        head_q <= slot(head_q, CntW'(1));
      end else begin
        count_q <= count_q + CntW'(1);
      end
    end else if (adv_i) begin
      head_q  <= slot(head_q, adv_n_i);
      count_q <= count_q - adv_n_i;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_addr] <= push_data_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

// ===== hw/rtl/stereo_frame_timestamp_pairing.sv =====
// Stereo frame pairing: a push is written into its queue and its status
// goes through the result register into the output register. A pop with
// neither queue empty scans the left queue oldest first; for each left entry
// one right entry is read per cycle from the right queue's single read port
// and fed through one shared 64-bit difference and compare unit. A pop that
// finds nothing runs the full scan, then drops the older front entry; a pop
// with either queue empty returns the empty status. The block takes one
// request at a time; in_ready_o is low while a request is in work and while
// its result waits for the output register to free up.
`timescale 1ns / 1ps

module stereo_frame_timestamp_pairing #(
  parameter int unsigned QUEUE_DEPTH = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sftp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sftp_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sftp_pkg::GapBits-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TimeBits = sftp_pkg::TimeBits;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_CHECK,
    S_FETCH,
    S_FRONT,
    S_DROP,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      i_q;
  logic [CntW-1:0]      jr_q;
  logic                 s1_v_q;
  logic [CntW-1:0]      s1_j_q;
  logic                 d_v_q;
  logic [CntW-1:0]      dj_q;
  logic [TimeBits-1:0]  d_q;
  logic [TimeBits-1:0]  best_q;
  logic [CntW-1:0]      bestj_q;
  sftp_pkg::out_t       res_q;
  sftp_pkg::out_t       out_q;
  logic                 out_valid_q;
  logic [sftp_pkg::GapBits-1:0] gap_q;

  logic                 in_fire;
  logic                 push_l;
  logic                 push_r;
  sftp_pkg::entry_t     push_data;
  logic                 adv_l;
  logic                 adv_r;
  logic [CntW-1:0]      adv_n_l;
  logic [CntW-1:0]      adv_n_r;
  logic [CntW-1:0]      rd_off_r;
  sftp_pkg::entry_t     l_rd;
  sftp_pkg::entry_t     r_rd;
  logic [CntW-1:0]      l_count;
  logic [CntW-1:0]      r_count;
  logic                 l_full;
  logic                 r_full;
  logic [TimeBits:0]    sub_ab;
  logic                 a_lt_b;
  logic [TimeBits-1:0]  diff;

  // Result that carries only a status code, with the pair fields at zero.
  function automatic sftp_pkg::out_t status_only(logic [2:0] st);
    sftp_pkg::out_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Push requests go straight into the selected queue.
  assign push_l          = in_fire && (in_data_i.command == sftp_pkg::CmdPushLeft);
  assign push_r          = in_fire && (in_data_i.command == sftp_pkg::CmdPushRight);
  assign push_data.stamp = in_data_i.frame_time;
  assign push_data.tag   = in_data_i.frame_tag[sftp_pkg::TagBits-1:0];

  assign l_full = (l_count == CntW'(QUEUE_DEPTH));
  assign r_full = (r_count == CntW'(QUEUE_DEPTH));

  // Queue trimming after a pair or after a failed scan.
  always_comb begin
    adv_l   = 1'b0;
    adv_r   = 1'b0;
    adv_n_l = i_q + CntW'(1);
    adv_n_r = bestj_q + CntW'(1);
    if (state_q == S_FETCH) begin
      adv_l = 1'b1;
      adv_r = 1'b1;
    end else if (state_q == S_DROP) begin
      adv_l   = a_lt_b;
      adv_r   = !a_lt_b;
      adv_n_l = CntW'(1);
      adv_n_r = CntW'(1);
    end
  end

  // Right read offset: scan counter, then the best match or the front entry.
  always_comb begin
    case (state_q)
      S_CHECK: rd_off_r = bestj_q;
      S_FRONT: rd_off_r = '0;
      default: rd_off_r = jr_q;
    endcase
  end

  sftp_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_left_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_l),
    .push_data_i(push_data),
    .adv_i      (adv_l),
    .adv_n_i    (adv_n_l),
    .rd_off_i   (i_q),
    .rd_data_o  (l_rd),
    .count_o    (l_count)
  );

  sftp_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_right_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_r),
    .push_data_i(push_data),
    .adv_i      (adv_r),
    .adv_n_i    (adv_n_r),
    .rd_off_i   (rd_off_r),
    .rd_data_o  (r_rd),
    .count_o    (r_count)
  );

  // Shared difference unit: absolute left-right difference and the ordering of the two.
  assign sub_ab = {1'b0, l_rd.stamp} - {1'b0, r_rd.stamp};
  assign a_lt_b = sub_ab[TimeBits];
  assign diff   = a_lt_b ? (r_rd.stamp - l_rd.stamp) : sub_ab[TimeBits-1:0];

  // Gap register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= sftp_pkg::GapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gap_q <= cfg_data_i;
    end
  end

  // Sequencer, scan pipeline and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      jr_q        <= '0;
      s1_v_q      <= 1'b0;
      s1_j_q      <= '0;
      d_v_q       <= 1'b0;
      dj_q        <= '0;
      d_q         <= '0;
      best_q      <= '0;
      bestj_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data_i.command)
              sftp_pkg::CmdPushLeft: begin
                res_q   <= status_only(l_full ? sftp_pkg::StStoredDrop : sftp_pkg::StStored);
                state_q <= S_EMIT;
              end
              sftp_pkg::CmdPushRight: begin
                res_q   <= status_only(r_full ? sftp_pkg::StStoredDrop : sftp_pkg::StStored);
                state_q <= S_EMIT;
              end
              default: begin
                // A pop request, also for the unused code.
                if ((l_count == '0) || (r_count == '0)) begin
                  res_q   <= status_only(sftp_pkg::StEmpty);
                  state_q <= S_EMIT;
                end else begin
                  i_q     <= '0;
                  state_q <= S_LOAD;
                end
              end
            endcase
          end
        end
        S_LOAD: begin
          // Left entry i is being read; restart the right scan.
          jr_q    <= '0;
          s1_v_q  <= 1'b0;
          d_v_q   <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (jr_q < r_count) begin
            jr_q   <= jr_q + CntW'(1);
            s1_v_q <= 1'b1;
            s1_j_q <= jr_q;
          end else begin
            s1_v_q <= 1'b0;
          end
          d_v_q <= s1_v_q;
          dj_q  <= s1_j_q;
          d_q   <= diff;
          // Keep the earliest right entry on equal differences.
          if (d_v_q && ((dj_q == '0) || (d_q < best_q))) begin
            best_q  <= d_q;
            bestj_q <= dj_q;
          end
          if ((jr_q == r_count) && !s1_v_q && !d_v_q) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (best_q <= TimeBits'(gap_q)) begin
            state_q <= S_FETCH;
          end else if ((i_q + CntW'(1)) == l_count) begin
            i_q     <= '0;
            state_q <= S_FRONT;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_LOAD;
          end
        end
        S_FETCH: begin
          res_q.status     <= sftp_pkg::StPair;
          res_q.left_time  <= l_rd.stamp;
          res_q.left_tag   <= 8'(l_rd.tag);
          res_q.right_time <= r_rd.stamp;
          res_q.right_tag  <= 8'(r_rd.tag);
          state_q          <= S_EMIT;
        end
        S_FRONT: begin
          // Both front entries are being read.
          state_q <= S_DROP;
        end
        S_DROP: begin
          res_q   <= status_only(sftp_pkg::StNoPair);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/sftp_checker.sv =====
// Port-level checker for the stereo frame pairing block, bound to the top level.
`timescale 1ns / 1ps
`include "stereo_frame_timestamp_pairing_defines.svh"

module sftp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input sftp_pkg::out_t               out_data_o
);

  logic out_stall;
  logic pair_clear;

  // A result is offered but not taken.
  assign out_stall  = out_valid_o && !out_ready_i;
  // All four pair fields are zero.
  assign pair_clear = (out_data_o.left_time == '0) && (out_data_o.left_tag == '0) &&
                      (out_data_o.right_time == '0) && (out_data_o.right_tag == '0);

  // A result waiting for the consumer stays up.
  `SFTP_ASSERT_NXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `SFTP_ASSERT_NXT(a_out_stable, out_stall, $stable(out_data_o), "stalled result changed")

  // The block works on one request at a time.
  `SFTP_ASSERT_NXT(a_one_request, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

  // Only a found pair carries frame data.
  `SFTP_ASSERT_IMP(a_pair_fields, out_valid_o && (out_data_o.status != sftp_pkg::StPair), pair_clear, "pair fields set")

endmodule

bind stereo_frame_timestamp_pairing sftp_checker u_sftp_checker (.*);
